// ===== rtl/priority_task_queue_macros.svh =====
// Assertion macros used by the queue top level.
`ifndef PRIORITY_TASK_QUEUE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, skipped while reset is high.
`define PTQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, skipped while reset is high.
`define PTQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PTQ_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PTQ_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/ptq_pkg.sv =====
package ptq_pkg;

   localparam int DEPTH      = 16;
   localparam int TASK_WIDTH = 8;
   localparam int PRIO_WIDTH = 8;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);

   // Request kinds; the fourth code is unused and leaves the queue alone.
   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_POP    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_ZERO  = 3'd1,
      IDX_ONE   = 3'd2,
      IDX_COUNT = 3'd3,
      IDX_INC   = 3'd4,
      IDX_DEC   = 3'd5
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_UP   = 2'd1,  // entry read at idx-1 lands at idx
      WR_DOWN = 2'd2,  // entry read at idx lands at idx-1
      WR_NEW  = 2'd3   // request entry lands at idx
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   typedef struct packed {
      logic [TASK_WIDTH-1:0] task_id;
      logic [PRIO_WIDTH-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic       capture;
      idx_op_type idx_op;
      logic       pos_load;
      logic       rd_prev;
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      logic       pop_load;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       empty;
      logic       idx_at_count;
      logic       idx_at_pos;
      logic       prio_greater;
   } stat_type;

endpackage

// ===== rtl/priority_task_queue.sv =====
// Bounded task queue of 16 entries (task id, priority), head served first.
// Raise start with req_kind/req_task_id/req_priority_req while busy is low;
// the transaction is taken on that edge. Kinds: append at the tail, insert
// ahead of the first entry with a strictly larger priority (equal priorities
// keep arrival order), pop the head. Every transaction yields exactly one
// result, shown for one cycle with rsp_strobe high; the receiver cannot
// stall, so sample it then. rsp_status flags a push into a full queue
// (dropped) or a pop of an empty queue; rsp_now_empty gives the fill state
// after the operation. A dropped push, an empty pop or the unused kind code
// is answered straight from decode; an append writes the tail slot; an insert
// scans from the head for its slot, then shifts the entries from that slot on
// up by one; a pop reads the head, then moves every later entry down by one.
// The entry store is one memory with a single write port and a registered
// read port, so each entry moved or compared takes a read state and then a write or compare state.
// busy falls in the strobe cycle, so the next transaction can start there.
`include "priority_task_queue_macros.svh"

module priority_task_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic [ptq_pkg::TASK_WIDTH-1:0] req_task_id,
   input  logic [ptq_pkg::PRIO_WIDTH-1:0] req_priority_req,
   output logic                           rsp_strobe,
   output logic                           rsp_pop_valid,
   output logic [ptq_pkg::TASK_WIDTH-1:0] rsp_popped_task,
   output logic [ptq_pkg::PRIO_WIDTH-1:0] rsp_popped_priority,
   output logic                           rsp_now_empty,
   output logic [1:0]                     rsp_status
);

   ptq_pkg::cmd_type  cmd;
   ptq_pkg::stat_type stat;

   // Sequencer: decode the transaction, scan, shift, pop and move, respond.
   ptq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Entry memory, fill count, index registers and result registers.
   ptq_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_task_id         (req_task_id),
      .req_priority_req    (req_priority_req),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_strobe          (rsp_strobe),
      .rsp_pop_valid       (rsp_pop_valid),
      .rsp_popped_task     (rsp_popped_task),
      .rsp_popped_priority (rsp_popped_priority),
      .rsp_now_empty       (rsp_now_empty),
      .rsp_status          (rsp_status)
   );

   // The fill count never steps past either end.
   `PTQ_ASSERT_IMP(a_no_overfill, clock, reset, cmd.cnt_op == ptq_pkg::CNT_INC, !stat.full, "count increment while full")
   `PTQ_ASSERT_IMP(a_no_underflow, clock, reset, cmd.cnt_op == ptq_pkg::CNT_DEC, !stat.empty, "count decrement while empty")
   // A result is only shown once the sequencer is back at rest.
   `PTQ_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result strobe while busy")
   // A successful pop always reports ok status.
   `PTQ_ASSERT_IMP(a_pop_status, clock, reset, rsp_strobe && rsp_pop_valid, rsp_status == ptq_pkg::STATUS_OK, "pop result with error status")
   // A taken transaction keeps the block busy the next cycle.
   `PTQ_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")

endmodule

// ===== rtl/ptq_ctrl.sv =====
module ptq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptq_pkg::stat_type stat,
   output ptq_pkg::cmd_type  cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DECODE   = 12'b0000_0000_0010,
      ST_SCAN_RD  = 12'b0000_0000_0100,
      ST_SCAN_CHK = 12'b0000_0000_1000,
      ST_SHIFT_RD = 12'b0000_0001_0000,
      ST_SHIFT_WR = 12'b0000_0010_0000,
      ST_PUT      = 12'b0000_0100_0000,
      ST_POP_RD   = 12'b0000_1000_0000,
      ST_POP_CAP  = 12'b0001_0000_0000,
      ST_MOVE_RD  = 12'b0010_0000_0000,
      ST_MOVE_WR  = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.idx_op   = ptq_pkg::IDX_HOLD;
      cmd.pos_load = 1'b0;
      cmd.rd_prev  = 1'b0;
      cmd.wr_op    = ptq_pkg::WR_NONE;
      cmd.cnt_op   = ptq_pkg::CNT_HOLD;
      cmd.pop_load = 1'b0;
      cmd.respond  = 1'b0;
      cmd.status   = ptq_pkg::STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.kind)
               ptq_pkg::KIND_APPEND: begin
                  if (stat.full) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ptq_pkg::STATUS_FULL;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.idx_op = ptq_pkg::IDX_COUNT;
                     state_in   = ST_PUT;
                  end
               end
               ptq_pkg::KIND_INSERT: begin
                  if (stat.full) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ptq_pkg::STATUS_FULL;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.idx_op = ptq_pkg::IDX_ZERO;
                     state_in   = ST_SCAN_RD;
                  end
               end
               ptq_pkg::KIND_POP: begin
                  if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ptq_pkg::STATUS_EMPTY;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.idx_op = ptq_pkg::IDX_ZERO;
                     state_in   = ST_POP_RD;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
            endcase
         end
         ST_SCAN_RD: begin
            if (stat.idx_at_count) begin
               cmd.pos_load = 1'b1;
               state_in     = ST_SHIFT_RD;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.prio_greater) begin
               cmd.pos_load = 1'b1;
               cmd.idx_op   = ptq_pkg::IDX_COUNT;
               state_in     = ST_SHIFT_RD;
            end else begin
               cmd.idx_op = ptq_pkg::IDX_INC;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (stat.idx_at_pos) begin
               state_in = ST_PUT;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_op  = ptq_pkg::WR_UP;
            cmd.idx_op = ptq_pkg::IDX_DEC;
            state_in   = ST_SHIFT_RD;
         end
         ST_PUT: begin
            cmd.wr_op  = ptq_pkg::WR_NEW;
            cmd.cnt_op = ptq_pkg::CNT_INC;
            state_in   = ST_FINISH;
         end
         ST_POP_RD: begin
            state_in = ST_POP_CAP;
         end
         ST_POP_CAP: begin
            cmd.pop_load = 1'b1;
            cmd.idx_op   = ptq_pkg::IDX_ONE;
            state_in     = ST_MOVE_RD;
         end
         ST_MOVE_RD: begin
            if (stat.idx_at_count) begin
               cmd.cnt_op = ptq_pkg::CNT_DEC;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_MOVE_WR;
            end
         end
         ST_MOVE_WR: begin
            cmd.wr_op  = ptq_pkg::WR_DOWN;
            cmd.idx_op = ptq_pkg::IDX_INC;
            state_in   = ST_MOVE_RD;
         end
         ST_FINISH: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ptq_dpath.sv =====
module ptq_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       req_kind,
   input  logic [ptq_pkg::TASK_WIDTH-1:0]   req_task_id,
   input  logic [ptq_pkg::PRIO_WIDTH-1:0]   req_priority_req,
   input  ptq_pkg::cmd_type                 cmd,
   output ptq_pkg::stat_type                stat,
   output logic                             rsp_strobe,
   output logic                             rsp_pop_valid,
   output logic [ptq_pkg::TASK_WIDTH-1:0]   rsp_popped_task,
   output logic [ptq_pkg::PRIO_WIDTH-1:0]   rsp_popped_priority,
   output logic                             rsp_now_empty,
   output logic [1:0]                       rsp_status
);

   ptq_pkg::entry_type mem [ptq_pkg::DEPTH];

   logic [1:0]                     kind_ff;
   ptq_pkg::entry_type             req_ff;
   ptq_pkg::entry_type             rd_data_ff;
   ptq_pkg::entry_type             pop_ff;
   logic                           pop_valid_ff;
   logic [ptq_pkg::COUNT_W-1:0]    count_ff;
   logic [ptq_pkg::COUNT_W-1:0]    count_in;
   logic [ptq_pkg::COUNT_W-1:0]    idx_ff;
   logic [ptq_pkg::COUNT_W-1:0]    idx_in;
   logic [ptq_pkg::COUNT_W-1:0]    pos_ff;
   logic                           rsp_strobe_ff;
   logic                           rsp_pop_valid_ff;
   ptq_pkg::entry_type             rsp_entry_ff;
   logic                           rsp_now_empty_ff;
   logic [1:0]                     rsp_status_ff;

   logic [ptq_pkg::ADDR_W-1:0]     idx_addr;
   logic [ptq_pkg::ADDR_W-1:0]     prev_addr;
   logic [ptq_pkg::ADDR_W-1:0]     rd_addr;
   logic [ptq_pkg::ADDR_W-1:0]     wr_addr;
   ptq_pkg::entry_type             wr_data;
   logic                           wr_en;

   assign idx_addr  = idx_ff[ptq_pkg::ADDR_W-1:0];
   assign prev_addr = idx_addr - ptq_pkg::ADDR_W'(1);
   assign rd_addr   = cmd.rd_prev ? prev_addr : idx_addr;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_addr;
      wr_data = rd_data_ff;
      case (cmd.wr_op)
         ptq_pkg::WR_UP: begin
            wr_en = 1'b1;
         end
         ptq_pkg::WR_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = prev_addr;
         end
         ptq_pkg::WR_NEW: begin
            wr_en   = 1'b1;
            wr_data = req_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      case (cmd.idx_op)
         ptq_pkg::IDX_ZERO:  idx_in = '0;
         ptq_pkg::IDX_ONE:   idx_in = ptq_pkg::COUNT_W'(1);
         ptq_pkg::IDX_COUNT: idx_in = count_ff;
         ptq_pkg::IDX_INC:   idx_in = idx_ff + ptq_pkg::COUNT_W'(1);
         ptq_pkg::IDX_DEC:   idx_in = idx_ff - ptq_pkg::COUNT_W'(1);
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         ptq_pkg::CNT_INC: count_in = count_ff + ptq_pkg::COUNT_W'(1);
         ptq_pkg::CNT_DEC: count_in = count_ff - ptq_pkg::COUNT_W'(1);
         default:          count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.pos_load) begin
         pos_ff <= idx_ff;
      end
      if (cmd.capture) begin
         kind_ff         <= req_kind;
         req_ff.task_id  <= req_task_id;
         req_ff.prio     <= req_priority_req;
         pop_ff          <= '0;
         pop_valid_ff    <= 1'b0;
      end else if (cmd.pop_load) begin
         pop_ff       <= rd_data_ff;
         pop_valid_ff <= 1'b1;
      end
      if (cmd.respond) begin
         rsp_pop_valid_ff <= pop_valid_ff;
         rsp_entry_ff     <= pop_ff;
         rsp_now_empty_ff <= (count_ff == '0);
         rsp_status_ff    <= cmd.status;
      end
   end

   assign stat.kind         = kind_ff;
   assign stat.full         = (count_ff == ptq_pkg::COUNT_W'(ptq_pkg::DEPTH));
   assign stat.empty        = (count_ff == '0);
   assign stat.idx_at_count = (idx_ff == count_ff);
   assign stat.idx_at_pos   = (idx_ff == pos_ff);
   assign stat.prio_greater = (rd_data_ff.prio > req_ff.prio);

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_pop_valid       = rsp_pop_valid_ff;
   assign rsp_popped_task     = rsp_entry_ff.task_id;
   assign rsp_popped_priority = rsp_entry_ff.prio;
   assign rsp_now_empty       = rsp_now_empty_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

// ===== tb/priority_task_queue_checker.sv =====
`timescale 1ns / 1ps

module priority_task_queue_checker
   import ptq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [TASK_WIDTH-1:0] req_task_id,
   input  logic [PRIO_WIDTH-1:0] req_priority_req,
   input  logic                  rsp_strobe,
   input  logic                  rsp_pop_valid,
   input  logic [TASK_WIDTH-1:0] rsp_popped_task,
   input  logic [PRIO_WIDTH-1:0] rsp_popped_priority,
   input  logic                  rsp_now_empty,
   input  logic [1:0]            rsp_status,
   input  logic                  wrap_up,
   output int                    failures,
   output int                    pending
);

   typedef struct packed {
      logic                  pop_valid;
      logic [TASK_WIDTH-1:0] task_id;
      logic [PRIO_WIDTH-1:0] prio;
      logic                  now_empty;
      status_type            status;
   } queue_reply_t;

   // Shadow copy of the queue, head at index 0.
   logic [TASK_WIDTH-1:0] task_store [DEPTH];
   logic [PRIO_WIDTH-1:0] prio_store [DEPTH];
   int                    held = 0;

   queue_reply_t replies_due [$];
   int           reported = 0;
   logic         wrapped = 1'b0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic queue_reply_t apply_request(logic [1:0]            kind,
                                                  logic [TASK_WIDTH-1:0] id,
                                                  logic [PRIO_WIDTH-1:0] prio);
      queue_reply_t r;
      int           slot;
      r        = '0;
      r.status = STATUS_OK;
      case (kind)
         KIND_APPEND, KIND_INSERT: begin
            if (held == DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot = held;
               // Land ahead of the first strictly larger priority.
               if (kind == KIND_INSERT) begin
                  for (int i = held - 1; i >= 0; i--)
                     if (prio_store[i] > prio) slot = i;
               end
               for (int i = held; i > slot; i--) begin
                  task_store[i] = task_store[i-1];
                  prio_store[i] = prio_store[i-1];
               end
               task_store[slot] = id;
               prio_store[slot] = prio;
               held++;
            end
         end
         KIND_POP: begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.pop_valid = 1'b1;
               r.task_id   = task_store[0];
               r.prio      = prio_store[0];
               for (int i = 1; i < held; i++) begin
                  task_store[i-1] = task_store[i];
                  prio_store[i-1] = prio_store[i];
               end
               held--;
            end
         end
         default: ;
      endcase
      r.now_empty = (held == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply_t got;
      queue_reply_t want;
      if (!reset) begin
         if (rsp_strobe) begin
            got = {rsp_pop_valid, rsp_popped_task, rsp_popped_priority,
                   rsp_now_empty, status_type'(rsp_status)};
            if (replies_due.size() == 0) begin
               failures++;
               if (reported < 10)
                  $display("%0t: unexpected result pop_valid=%0b task=%0h prio=%0h empty=%0b status=%0d",
                           $realtime, got.pop_valid, got.task_id, got.prio,
                           got.now_empty, got.status);
               reported++;
            end else begin
               want = replies_due.pop_front();
               if (got.pop_valid !== want.pop_valid || got.task_id !== want.task_id ||
                   got.prio !== want.prio || got.now_empty !== want.now_empty ||
                   got.status !== want.status) begin
                  failures++;
                  if (reported < 10) begin
                     $display("%0t: mismatch expected pop_valid=%0b task=%0h prio=%0h empty=%0b status=%0d",
                              $realtime, want.pop_valid, want.task_id, want.prio,
                              want.now_empty, want.status);
                     $display("%0t:          actual   pop_valid=%0b task=%0h prio=%0h empty=%0b status=%0d",
                              $realtime, got.pop_valid, got.task_id, got.prio,
                              got.now_empty, got.status);
                  end
                  reported++;
               end
            end
         end
         if (start && !busy)
            replies_due.push_back(apply_request(req_kind, req_task_id, req_priority_req));
         if (wrap_up && !wrapped) begin
            wrapped = 1'b1;
            if (replies_due.size() != 0) begin
               $display("%0t: %0d results never arrived", $realtime, replies_due.size());
               failures += replies_due.size();
            end
         end
      end
      pending <= replies_due.size();
   end

endmodule

// ===== tb/tb_priority_task_queue.sv =====
`timescale 1ns / 1ps

module tb_priority_task_queue;
   import ptq_pkg::*;

   // The fourth kind code has no package name; the block ignores it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_kind = KIND_APPEND;
   logic [TASK_WIDTH-1:0] req_task_id = '0;
   logic [PRIO_WIDTH-1:0] req_priority_req = '0;
   logic                  rsp_strobe;
   logic                  rsp_pop_valid;
   logic [TASK_WIDTH-1:0] rsp_popped_task;
   logic [PRIO_WIDTH-1:0] rsp_popped_priority;
   logic                  rsp_now_empty;
   logic [1:0]            rsp_status;
   logic                  wrap_up = 1'b0;
   int                    fail_count;
   int                    pending;

   // Percent chance, checked each cycle, that the sender holds start low.
   int                    idle_pct = 9;

   always #10 clock = ~clock;

   priority_task_queue dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_task_id         (req_task_id),
      .req_priority_req    (req_priority_req),
      .rsp_strobe          (rsp_strobe),
      .rsp_pop_valid       (rsp_pop_valid),
      .rsp_popped_task     (rsp_popped_task),
      .rsp_popped_priority (rsp_popped_priority),
      .rsp_now_empty       (rsp_now_empty),
      .rsp_status          (rsp_status)
   );

   priority_task_queue_checker chk (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_task_id         (req_task_id),
      .req_priority_req    (req_priority_req),
      .rsp_strobe          (rsp_strobe),
      .rsp_pop_valid       (rsp_pop_valid),
      .rsp_popped_task     (rsp_popped_task),
      .rsp_popped_priority (rsp_popped_priority),
      .rsp_now_empty       (rsp_now_empty),
      .rsp_status          (rsp_status),
      .wrap_up             (wrap_up),
      .failures            (fail_count),
      .pending             (pending)
   );

   // Issue one transaction. Idle first with random junk on the request
   // fields, then raise start and hold it until an edge finds busy low.
   // Start is left high on return so back-to-back requests never toggle it
   // within one time step.
   task automatic issue(logic [1:0] kind, logic [TASK_WIDTH-1:0] id,
                        logic [PRIO_WIDTH-1:0] prio);
      while ($urandom_range(0, 99) < idle_pct) begin
         start            <= 1'b0;
         req_kind         <= 2'($urandom);
         req_task_id      <= TASK_WIDTH'($urandom);
         req_priority_req <= PRIO_WIDTH'($urandom);
         @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_task_id      <= id;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
   endtask

   // Hard stop in case the block hangs; far beyond the slowest good run.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                    counted;
      int                    block_left;
      int                    push_pct;
      int                    roll;
      int                    guard;
      logic                  narrow;
      logic [1:0]            kind;
      logic [PRIO_WIDTH-1:0] prio;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty-queue corner cases first.
      issue(KIND_POP, 8'h00, 8'h00);
      issue(KIND_UNUSED, 8'hFF, 8'hFF);
      issue(KIND_INSERT, 8'h7F, 8'h7F);   // insert into an empty queue
      issue(KIND_POP, 8'hFF, 8'hFF);
      issue(KIND_APPEND, 8'h00, 8'h10);
      issue(KIND_APPEND, 8'hFF, 8'hFF);
      // Lower priority than the head with two entries queued: go in front.
      issue(KIND_INSERT, 8'hA5, 8'h05);
      issue(KIND_INSERT, 8'h5A, 8'h80);   // land mid-queue
      issue(KIND_INSERT, 8'h01, 8'h05);   // tie with head: stay behind it
      issue(KIND_INSERT, 8'h02, 8'h00);   // new head at the lowest priority
      issue(KIND_INSERT, 8'h03, 8'hFF);   // tie with tail: go last
      issue(KIND_UNUSED, 8'h00, 8'h00);   // ignored while non-empty
      // Drain all seven entries, then pop once more on empty.
      repeat (8) issue(KIND_POP, TASK_WIDTH'($urandom), PRIO_WIDTH'($urandom));

      // Random part in three idling phases. Fill pressure and priority
      // spread change every block of requests, so the queue swings between
      // empty and full and runs of equal priorities show up often.
      block_left = 0;
      push_pct   = 50;
      narrow     = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 9 : (phase == 1) ? 73 : 0;
         counted  = 0;
         while (counted < 550) begin
            if (block_left == 0) begin
               block_left = $urandom_range(20, 60);
               case ($urandom_range(0, 3))
                  0: push_pct = 20;
                  1: push_pct = 50;
                  2: push_pct = 80;
                  default: push_pct = 95;
               endcase
               narrow = $urandom_range(0, 2) == 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
               kind = KIND_UNUSED;
            else if ($urandom_range(0, 99) < push_pct)
               kind = ($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_APPEND;
            else
               kind = KIND_POP;
            if (narrow)
               prio = PRIO_WIDTH'($urandom_range(0, 3));
            else if ($urandom_range(0, 9) == 0)
               prio = $urandom_range(0, 1) ? '1 : '0;
            else
               prio = PRIO_WIDTH'($urandom);
            issue(kind, TASK_WIDTH'($urandom), prio);
            // Ignored requests do not advance the count.
            if (kind != KIND_UNUSED) begin
               counted++;
               block_left--;
            end
         end
      end

      // Drop start and let every outstanding result come back.
      start <= 1'b0;
      guard = 0;
      while (pending != 0 && guard < 400) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
